// ===== hdl/csv_field_tokenizer_row_slicer_unit_defines.svh =====
// Assertion macros for the CSV tokenizer and row slicer.
`ifndef CSV_FIELD_TOKENIZER_ROW_SLICER_UNIT_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_ROW_SLICER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CSVT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csv tokenizer check failed");

// Next-cycle implication.
`define CSVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csv tokenizer check failed");

`else

`define CSVT_ASSERT_NOW(lbl, ante, cons)
`define CSVT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/csvtok_pkg.sv =====
// Constants, types and helper functions of the CSV tokenizer and row slicer.
package csvtok_pkg;

    localparam int MAX_COLUMNS    = 64;
    localparam int ROW_COUNT_BITS = 32;
    localparam int CMP_W          = (ROW_COUNT_BITS > 32) ? ROW_COUNT_BITS : 32;

    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [15:0] FIELD_SAT = 16'hFFFF;
    localparam logic [5:0]  COL_SAT   = 6'd63;

    typedef enum logic [1:0] {
        CFG_FIRST_ROW,
        CFG_STOP_ROW,
        CFG_ROW_STEP,
        CFG_COLUMN_MASK
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_CHAR,
        SCAN_SEP
    } scan_kind_t;

    typedef logic [ROW_COUNT_BITS-1:0] row_cnt_t;

    typedef struct packed {
        scan_kind_t kind;
        logic       in_quotes;
        logic       quote_pending;
    } scan_t;

    typedef struct packed {
        logic [31:0] row_index;
        logic [5:0]  column_index;
        logic        char_valid;
        logic [7:0]  char_value;
        logic        field_end;
        logic        row_end;
        logic        field_count_error;
        logic        last;
    } result_t;

    // Quote state machine for one byte; the caller handles LF and ignores the result for it.
    function automatic scan_t scan_byte(logic [7:0] b, logic iq, logic qp);
        scan_t s;
        logic  outside;
        s.kind          = SCAN_NONE;
        s.in_quotes     = iq;
        s.quote_pending = 1'b0;
        outside         = 1'b0;
        if (qp) begin
            if (b == CH_QUOTE) begin
                s.kind = SCAN_CHAR;
            end
            else begin
                s.in_quotes = 1'b0;
                outside     = 1'b1;
            end
        end
        else if (iq) begin
            if (b == CH_QUOTE) begin
                s.quote_pending = 1'b1;
            end
            else begin
                s.kind = SCAN_CHAR;
            end
        end
        else if (b == CH_QUOTE) begin
            s.in_quotes = 1'b1;
        end
        else begin
            outside = 1'b1;
        end
        if (outside) begin
            if (b == CH_COMMA) begin
                s.kind = SCAN_SEP;
            end
            else if (b == CH_CR) begin
                s.kind = SCAN_NONE;
            end
            else begin
                s.kind = SCAN_CHAR;
            end
        end
        return s;
    endfunction

    function automatic logic [15:0] sat_inc16(logic [15:0] v);
        return (v == FIELD_SAT) ? v : v + 16'd1;
    endfunction

    function automatic row_cnt_t row_inc(row_cnt_t c);
        return (c == '1) ? c : c + row_cnt_t'(1);
    endfunction

    function automatic logic row_ge(row_cnt_t c, logic [31:0] v);
        return CMP_W'(c) >= CMP_W'(v);
    endfunction

    function automatic logic col_on(logic [15:0] f, logic [63:0] mask);
        return (f < 16'(MAX_COLUMNS)) && mask[f[5:0]];
    endfunction

    function automatic logic [5:0] col_index(logic [15:0] f);
        return (f > 16'(COL_SAT)) ? COL_SAT : f[5:0];
    endfunction

endpackage

// ===== hdl/csv_field_tokenizer_row_slicer_unit.sv =====
// Top level: CSV byte tokenizer, row selection and a four-entry result queue.
// Results are registered into the result queue when their byte is taken.
// Throughput: one byte per cycle while the result queue holds at most two results;
// a byte that flushes a held-back empty line can give two results, which the
// four-entry queue absorbs.
// Reset (rst_n low, asynchronous) clears the parser state, the queue and restores
// the register defaults; after a field count error the block drops all bytes until reset.
`include "csv_field_tokenizer_row_slicer_unit_defines.svh"

module csv_field_tokenizer_row_slicer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // end_of_file
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] row_index, [37:32] column_index,
                                   // [45:38] char_value, [47:46] zero
    output logic [3:0]  m_tuser,   // [0] char_valid, [1] field_end, [2] row_end,
                                   // [3] field_count_error
    output logic        m_tlast    // last
);

    // configuration registers
    logic [31:0] first_row_reg;
    logic [32:0] stop_row_reg;
    logic [15:0] row_step_reg;
    logic [63:0] column_mask_reg;

    // parser state
    logic                 in_quotes_reg,          in_quotes_next;
    logic                 quote_pending_reg,      quote_pending_next;
    logic                 header_done_reg,        header_done_next;
    logic [15:0]          header_field_total_reg, header_field_total_next;
    logic [15:0]          field_num_reg,          field_num_next;
    csvtok_pkg::row_cnt_t row_cnt_reg,            row_cnt_next;
    logic [15:0]          step_phase_reg,         step_phase_next;
    logic                 line_has_bytes_reg,     line_has_bytes_next;
    logic                 empty_pending_reg,      empty_pending_next;
    logic                 halted_reg,             halted_next;

    // result queue
    csvtok_pkg::result_t fifo_mem [4];
    logic [1:0]          wr_ptr_reg, wr_ptr_next;
    logic [1:0]          rd_ptr_reg, rd_ptr_next;
    logic [2:0]          count_reg,  count_next;

    logic accept;
    logic pop;

    // end-of-row terms, taken from the current state
    logic                 stopped0;
    logic                 ge_first0;
    logic                 sel0;
    logic                 row_err;
    logic [15:0]          step_eff;
    logic [15:0]          phase_after;
    csvtok_pkg::row_cnt_t cnt_after;
    csvtok_pkg::result_t  er_res;

    // data byte terms, taken from the state after an optional flushed empty line
    logic                 flush;
    logic                 iq_s;
    logic                 qp_s;
    logic [15:0]          fn_s;
    csvtok_pkg::row_cnt_t cnt_s;
    logic [15:0]          phase_s;
    logic                 stopped1;
    logic                 sel1;
    csvtok_pkg::scan_t    scan;
    csvtok_pkg::result_t  db_res;

    logic                 r0_valid;
    logic                 r1_valid;
    csvtok_pkg::result_t  push_a;
    csvtok_pkg::result_t  push_b;
    logic                 is_lf;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (count_reg <= 3'd2);
    assign m_tvalid = (count_reg != 3'd0);
    assign pop      = m_tvalid && m_tready;
    assign is_lf    = (s_tdata == csvtok_pkg::CH_LF);

    always_comb
    begin
        m_tdata = {2'b00, fifo_mem[rd_ptr_reg].char_value,
                   fifo_mem[rd_ptr_reg].column_index, fifo_mem[rd_ptr_reg].row_index};
        m_tuser = {fifo_mem[rd_ptr_reg].field_count_error, fifo_mem[rd_ptr_reg].row_end,
                   fifo_mem[rd_ptr_reg].field_end, fifo_mem[rd_ptr_reg].char_valid};
        m_tlast = fifo_mem[rd_ptr_reg].last;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_row_reg   <= '0;
            stop_row_reg    <= '1;
            row_step_reg    <= 16'd1;
            column_mask_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (csvtok_pkg::cfg_reg_t'(cfg_index))
                csvtok_pkg::CFG_FIRST_ROW:   first_row_reg   <= cfg_data[31:0];
                csvtok_pkg::CFG_STOP_ROW:    stop_row_reg    <= cfg_data[32:0];
                csvtok_pkg::CFG_ROW_STEP:    row_step_reg    <= cfg_data[15:0];
                csvtok_pkg::CFG_COLUMN_MASK: column_mask_reg <= cfg_data;
                default:                     first_row_reg   <= first_row_reg;
            endcase
        end
    end

    // row end on the current line
    always_comb
    begin
        stopped0  = !stop_row_reg[32] && csvtok_pkg::row_ge(row_cnt_reg, stop_row_reg[31:0]);
        ge_first0 = csvtok_pkg::row_ge(row_cnt_reg, first_row_reg);
        sel0      = !stopped0 && ge_first0 && (step_phase_reg == 16'd0);
        row_err   = (csvtok_pkg::sat_inc16(field_num_reg) != header_field_total_reg);
        step_eff  = (row_step_reg == 16'd0) ? 16'd1 : row_step_reg;
        if (!ge_first0)
        begin
            phase_after = step_phase_reg;
        end
        else if ((17'(step_phase_reg) + 17'd1) >= 17'(step_eff))
        begin
            phase_after = 16'd0;
        end
        else
        begin
            phase_after = step_phase_reg + 16'd1;
        end
        cnt_after = csvtok_pkg::row_inc(row_cnt_reg);

        er_res.row_index         = 32'(row_cnt_reg);
        er_res.column_index      = csvtok_pkg::col_index(field_num_reg);
        er_res.char_valid        = 1'b0;
        er_res.char_value        = 8'd0;
        er_res.field_end         = csvtok_pkg::col_on(field_num_reg, column_mask_reg);
        er_res.row_end           = 1'b1;
        er_res.field_count_error = row_err;
        er_res.last              = 1'b0;
    end

    // data byte, after a held-back empty line has been flushed if there was one
    always_comb
    begin
        flush    = empty_pending_reg;
        iq_s     = flush ? 1'b0 : in_quotes_reg;
        qp_s     = flush ? 1'b0 : quote_pending_reg;
        fn_s     = flush ? 16'd0 : field_num_reg;
        cnt_s    = flush ? cnt_after : row_cnt_reg;
        phase_s  = flush ? phase_after : step_phase_reg;
        stopped1 = !stop_row_reg[32] && csvtok_pkg::row_ge(cnt_s, stop_row_reg[31:0]);
        sel1     = !stopped1 && csvtok_pkg::row_ge(cnt_s, first_row_reg) &&
                   (phase_s == 16'd0);
        scan     = csvtok_pkg::scan_byte(s_tdata, iq_s, qp_s);

        db_res.row_index         = 32'(cnt_s);
        db_res.column_index      = csvtok_pkg::col_index(fn_s);
        db_res.char_valid        = (scan.kind == csvtok_pkg::SCAN_CHAR);
        db_res.char_value        = (scan.kind == csvtok_pkg::SCAN_CHAR) ? s_tdata : 8'd0;
        db_res.field_end         = (scan.kind == csvtok_pkg::SCAN_SEP);
        db_res.row_end           = 1'b0;
        db_res.field_count_error = 1'b0;
        db_res.last              = 1'b0;
    end

    // parser next state and results
    always_comb
    begin
        in_quotes_next          = in_quotes_reg;
        quote_pending_next      = quote_pending_reg;
        header_done_next        = header_done_reg;
        header_field_total_next = header_field_total_reg;
        field_num_next          = field_num_reg;
        row_cnt_next            = row_cnt_reg;
        step_phase_next         = step_phase_reg;
        line_has_bytes_next     = line_has_bytes_reg;
        empty_pending_next      = empty_pending_reg;
        halted_next             = halted_reg;
        r0_valid                = 1'b0;
        r1_valid                = 1'b0;

        if (accept && !halted_reg)
        begin
            if (s_tlast)
            begin
                // finish an open data row, then start over with a new header
                if (!empty_pending_reg && line_has_bytes_reg && header_done_reg && !stopped0)
                begin
                    r0_valid    = sel0;
                    halted_next = sel0 && row_err;
                end
                in_quotes_next          = 1'b0;
                quote_pending_next      = 1'b0;
                header_done_next        = 1'b0;
                header_field_total_next = 16'd0;
                field_num_next          = 16'd0;
                row_cnt_next            = '0;
                step_phase_next         = 16'd0;
                line_has_bytes_next     = 1'b0;
                empty_pending_next      = 1'b0;
            end
            else if (!header_done_reg)
            begin
                if (is_lf)
                begin
                    header_field_total_next = csvtok_pkg::sat_inc16(field_num_reg);
                    header_done_next        = 1'b1;
                    in_quotes_next          = 1'b0;
                    quote_pending_next      = 1'b0;
                    field_num_next          = 16'd0;
                    line_has_bytes_next     = 1'b0;
                end
                else
                begin
                    line_has_bytes_next = 1'b1;
                    in_quotes_next      = scan.in_quotes;
                    quote_pending_next  = scan.quote_pending;
                    if (scan.kind == csvtok_pkg::SCAN_SEP)
                    begin
                        field_num_next = csvtok_pkg::sat_inc16(field_num_reg);
                    end
                end
            end
            else if (!stopped0)
            begin
                if (flush || (is_lf && line_has_bytes_reg))
                begin
                    r0_valid            = sel0;
                    halted_next         = sel0 && row_err;
                    step_phase_next     = phase_after;
                    row_cnt_next        = cnt_after;
                    in_quotes_next      = 1'b0;
                    quote_pending_next  = 1'b0;
                    field_num_next      = 16'd0;
                    line_has_bytes_next = 1'b0;
                    empty_pending_next  = 1'b0;
                end
                if (!(sel0 && row_err && flush) && !stopped1 && !(is_lf && !flush &&
                    line_has_bytes_reg))
                begin
                    if (is_lf)
                    begin
                        // hold back an empty line until the next byte
                        empty_pending_next = 1'b1;
                    end
                    else
                    begin
                        line_has_bytes_next = 1'b1;
                        in_quotes_next      = scan.in_quotes;
                        quote_pending_next  = scan.quote_pending;
                        r1_valid            = (scan.kind != csvtok_pkg::SCAN_NONE) && sel1 &&
                                              csvtok_pkg::col_on(fn_s, column_mask_reg);
                        if (scan.kind == csvtok_pkg::SCAN_SEP)
                        begin
                            field_num_next = csvtok_pkg::sat_inc16(fn_s);
                        end
                        else
                        begin
                            field_num_next = fn_s;
                        end
                    end
                end
            end
        end

        // order results for the queue and mark the final one
        push_a      = r0_valid ? er_res : db_res;
        push_a.last = !(r0_valid && r1_valid);
        push_b      = db_res;
        push_b.last = 1'b1;

        wr_ptr_next = wr_ptr_reg + 2'(r0_valid) + 2'(r1_valid);
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(r0_valid) + 3'(r1_valid) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg          <= 1'b0;
            quote_pending_reg      <= 1'b0;
            header_done_reg        <= 1'b0;
            header_field_total_reg <= 16'd0;
            field_num_reg          <= 16'd0;
            row_cnt_reg            <= '0;
            step_phase_reg         <= 16'd0;
            line_has_bytes_reg     <= 1'b0;
            empty_pending_reg      <= 1'b0;
            halted_reg             <= 1'b0;
            wr_ptr_reg             <= 2'd0;
            rd_ptr_reg             <= 2'd0;
            count_reg              <= 3'd0;
        end
        else
        begin
            in_quotes_reg          <= in_quotes_next;
            quote_pending_reg      <= quote_pending_next;
            header_done_reg        <= header_done_next;
            header_field_total_reg <= header_field_total_next;
            field_num_reg          <= field_num_next;
            row_cnt_reg            <= row_cnt_next;
            step_phase_reg         <= step_phase_next;
            line_has_bytes_reg     <= line_has_bytes_next;
            empty_pending_reg      <= empty_pending_next;
            halted_reg             <= halted_next;
            wr_ptr_reg             <= wr_ptr_next;
            rd_ptr_reg             <= rd_ptr_next;
            count_reg              <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (r0_valid || r1_valid)
        begin
            fifo_mem[wr_ptr_reg] <= push_a;
        end
        if (r0_valid && r1_valid)
        begin
            fifo_mem[wr_ptr_reg + 2'd1] <= push_b;
        end
    end

    `CSVT_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= 3'd4)
    `CSVT_ASSERT_NOW(a_room_on_accept, s_tvalid && s_tready, count_reg <= 3'd2)
    `CSVT_ASSERT_NEXT(a_halt_sticks, halted_reg, halted_reg && count_reg <= $past(count_reg))
    `CSVT_ASSERT_NEXT(a_halt_reports, !halted_reg && halted_next, halted_reg && count_reg != 3'd0)

endmodule
